### design/sacd_pkg.sv
// Shared constants, types and register codes of the set-associative cache timing block.
`default_nettype none
package sacd_pkg;

    // Fixed field widths
    localparam int ADDR_W    = 32;
    localparam int BYTE_BITS = 2;
    localparam int COST_W    = 10;
    localparam int TOTAL_W   = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // Default geometry
    localparam int DEF_WAYS       = 4;
    localparam int DEF_INDEX_BITS = 8;
    localparam int DEF_WORD_BITS  = 1;
    localparam int DEF_ROW_SHIFT  = 6;

    // Fixed cycles added to every DRAM miss
    localparam logic [COST_W-1:0] DRAM_OVERHEAD = COST_W'(2);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOOKUP_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAS_TIME    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAS_TIME    = 2'd2;

    // Register reset values
    localparam logic [3:0] LOOKUP_TIME_RST = 4'd1;
    localparam logic [7:0] CAS_TIME_RST    = 8'd24;
    localparam logic [7:0] RAS_TIME_RST    = 8'd72;

    typedef struct packed {
        logic [3:0] lookup_time;
        logic [7:0] cas_time;
        logic [7:0] ras_time;
    } timing_cfg_t;

    typedef struct packed {
        logic hit;
        logic is_write;
        logic row_open;
    } access_info_t;

endpackage
`default_nettype wire

### design/sacd_ram.sv
// Simple dual-port synchronous memory with one write port and a registered read port.
`default_nettype none
module sacd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

### design/sacd_cost.sv
// Access cost under the DRAM open-row timing rules.
`default_nettype none
module sacd_cost (
    input  wire sacd_pkg::timing_cfg_t           cfg,
    input  wire sacd_pkg::access_info_t          info,
    output logic [sacd_pkg::COST_W-1:0]          cost
);

    logic [sacd_pkg::COST_W-1:0] base;
    logic [sacd_pkg::COST_W-1:0] cas_part;
    logic [sacd_pkg::COST_W-1:0] ras_part;

    always_comb begin
        // Hit lookup time, or the fixed overhead of a miss
        base     = info.hit ? sacd_pkg::COST_W'(cfg.lookup_time) : sacd_pkg::DRAM_OVERHEAD;
        // Writes pay two column accesses, read misses one
        cas_part = info.is_write ? {1'b0, cfg.cas_time, 1'b0}
                                 : sacd_pkg::COST_W'(cfg.cas_time);
        ras_part = info.row_open ? '0 : sacd_pkg::COST_W'(cfg.ras_time);
        if (info.hit && !info.is_write) begin
            cost = base;
        end else begin
            cost = base + cas_part + ras_part;
        end
    end

endmodule
`default_nettype wire

### design/set_assoc_cache_dram_timing.sv
// Top level: set-associative cache lookup with round-robin fill and DRAM open-row timing.
//
// Each access transfer on the s_ channel carries a byte address and a mode bit (read or
// write-through). The set's valid bits and tags sit in two synchronous memories holding one
// row per set; an access passes through three steps: accept and memory read, tag compare
// with cost and row write-back, then the saturating total and the result register, which
// waits while the result channel is busy. The block takes one access at a time because
// each access reads, modifies and writes back its set's row and the shared fill pointer.
// After reset a clearing pass over all 2^INDEX_BITS sets zeroes the valid memory; no access
// is taken during it, while configuration writes are taken at any time. Configuration must
// be written by the user only while the block is idle; the block does not enforce this.
`default_nettype none
module set_assoc_cache_dram_timing #(
    parameter int WAYS       = sacd_pkg::DEF_WAYS,
    parameter int INDEX_BITS = sacd_pkg::DEF_INDEX_BITS,
    parameter int WORD_BITS  = sacd_pkg::DEF_WORD_BITS,
    parameter int ROW_SHIFT  = sacd_pkg::DEF_ROW_SHIFT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // access channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [31:0]                       s_tdata,  // address[31:0]
    input  wire logic                              s_tuser,  // mode[0]
    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // hit[0], dram_used[1], row_was_open[2], access_cycles[12:3], total_cycles[60:13]
    output logic [63:0]                            m_tdata,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sacd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sacd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ADDR_W = sacd_pkg::ADDR_W;
    localparam int OFF_W  = sacd_pkg::BYTE_BITS + WORD_BITS;
    localparam int TAG_W  = ADDR_W - OFF_W - INDEX_BITS;
    localparam int ROW_W  = ADDR_W - ROW_SHIFT;
    localparam int SETS   = 1 << INDEX_BITS;
    localparam int VP_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int COST_W = sacd_pkg::COST_W;
    localparam int TOT_W  = sacd_pkg::TOTAL_W;

    localparam logic [VP_W-1:0]  VP_LAST  = VP_W'(WAYS - 1);
    localparam logic [INDEX_BITS-1:0] SET_LAST = INDEX_BITS'(SETS - 1);
    localparam logic [TOT_W-1:0] TOT_MAX  = '1;

    // State codes
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;
    localparam logic [1:0] ST_SUM   = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [INDEX_BITS-1:0]   clr_cnt_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic                    mode_reg;
    logic [VP_W-1:0]         victim_reg;
    logic [ROW_W-1:0]        open_row_reg;
    logic                    open_row_valid_reg;
    logic [TOT_W-1:0]        total_reg;
    sacd_pkg::timing_cfg_t   cfg_reg;

    logic                    hit_reg;
    logic                    dram_reg;
    logic                    open_reg;
    logic [COST_W-1:0]       cost_reg;

    logic                    m_tvalid_reg;
    logic                    out_hit_reg;
    logic                    out_dram_reg;
    logic                    out_open_reg;
    logic [COST_W-1:0]       out_cost_reg;
    logic [TOT_W-1:0]        out_total_reg;

    logic                    s_accept;
    logic                    out_free;

    // Memory ports
    logic                        vmem_we;
    logic [INDEX_BITS-1:0]       vmem_waddr;
    logic [WAYS-1:0]             vmem_wdata;
    logic [WAYS-1:0]             vmem_rdata;
    logic                        tmem_we;
    logic [WAYS*TAG_W-1:0]       tmem_wdata;
    logic [WAYS*TAG_W-1:0]       tmem_rdata;

    // Lookup logic
    logic [TAG_W-1:0]            cur_tag;
    logic [INDEX_BITS-1:0]       cur_set;
    logic [ROW_W-1:0]            cur_row;
    logic                        look_hit;
    logic                        look_dram;
    logic                        look_open;
    logic [WAYS-1:0]             valid_fill;
    sacd_pkg::access_info_t      info;
    logic [COST_W-1:0]           look_cost;
    logic [TOT_W:0]              sum;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign cur_tag = addr_reg[ADDR_W-1 -: TAG_W];
    assign cur_set = addr_reg[OFF_W +: INDEX_BITS];
    assign cur_row = addr_reg[ADDR_W-1:ROW_SHIFT];

    // Tag compare across the ways and the row rewritten on a fill
    always_comb begin
        look_hit   = 1'b0;
        valid_fill = vmem_rdata;
        tmem_wdata = tmem_rdata;
        for (int w = 0; w < WAYS; w++) begin
            if (vmem_rdata[w] && (tmem_rdata[w*TAG_W +: TAG_W] == cur_tag)) begin
                look_hit = 1'b1;
            end
            if (victim_reg == VP_W'(w)) begin
                valid_fill[w]              = 1'b1;
                tmem_wdata[w*TAG_W +: TAG_W] = cur_tag;
            end
        end
    end

    assign look_dram = !look_hit || mode_reg;
    assign look_open = look_dram && open_row_valid_reg && (cur_row == open_row_reg);

    assign info.hit      = look_hit;
    assign info.is_write = mode_reg;
    assign info.row_open = look_open;

    sacd_cost u_cost (
        .cfg  (cfg_reg),
        .info (info),
        .cost (look_cost)
    );

    // Valid memory: written by the clearing pass and by fills
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            vmem_we    = 1'b1;
            vmem_waddr = clr_cnt_reg;
            vmem_wdata = '0;
        end else begin
            vmem_we    = (state_reg == ST_LOOK) && !look_hit;
            vmem_waddr = cur_set;
            vmem_wdata = valid_fill;
        end
    end

    assign tmem_we = (state_reg == ST_LOOK) && !look_hit;

    sacd_ram #(
        .WIDTH (WAYS),
        .DEPTH (SETS)
    ) u_valid_ram (
        .aclk  (aclk),
        .we    (vmem_we),
        .waddr (vmem_waddr),
        .wdata (vmem_wdata),
        .re    (s_accept),
        .raddr (s_tdata[OFF_W +: INDEX_BITS]),
        .rdata (vmem_rdata)
    );

    sacd_ram #(
        .WIDTH (WAYS * TAG_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (tmem_we),
        .waddr (cur_set),
        .wdata (tmem_wdata),
        .re    (s_accept),
        .raddr (s_tdata[OFF_W +: INDEX_BITS]),
        .rdata (tmem_rdata)
    );

    // Saturating running total
    assign sum = {1'b0, total_reg} + (TOT_W + 1)'(cost_reg);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == SET_LAST) state_next = ST_IDLE;
            ST_IDLE:  if (s_accept) state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_SUM;
            ST_SUM:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_CLEAR;
            clr_cnt_reg         <= '0;
            victim_reg          <= '0;
            open_row_reg        <= '0;
            open_row_valid_reg  <= 1'b0;
            total_reg           <= '0;
            m_tvalid_reg        <= 1'b0;
            cfg_reg.lookup_time <= sacd_pkg::LOOKUP_TIME_RST;
            cfg_reg.cas_time    <= sacd_pkg::CAS_TIME_RST;
            cfg_reg.ras_time    <= sacd_pkg::RAS_TIME_RST;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            // Fill pointer and open row update after the lookup
            if (state_reg == ST_LOOK) begin
                if (!look_hit) begin
                    victim_reg <= (victim_reg == VP_LAST) ? '0 : victim_reg + 1'b1;
                end
                if (look_dram) begin
                    open_row_valid_reg <= 1'b1;
                    if (!look_open) begin
                        open_row_reg <= cur_row;
                    end
                end
            end
            if (state_reg == ST_SUM && out_free) begin
                total_reg    <= sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            // Configuration writes; unknown indexes are ignored
            if (cfg_valid) begin
                case (cfg_index)
                    sacd_pkg::REG_LOOKUP_TIME: cfg_reg.lookup_time <= cfg_data[3:0];
                    sacd_pkg::REG_CAS_TIME:    cfg_reg.cas_time    <= cfg_data;
                    sacd_pkg::REG_RAS_TIME:    cfg_reg.ras_time    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            addr_reg <= s_tdata;
            mode_reg <= s_tuser;
        end
        if (state_reg == ST_LOOK) begin
            hit_reg  <= look_hit;
            dram_reg <= look_dram;
            open_reg <= look_open;
            cost_reg <= look_cost;
        end
        if (state_reg == ST_SUM && out_free) begin
            out_hit_reg   <= hit_reg;
            out_dram_reg  <= dram_reg;
            out_open_reg  <= open_reg;
            out_cost_reg  <= cost_reg;
            out_total_reg <= sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_total_reg, out_cost_reg, out_open_reg, out_dram_reg,
                       out_hit_reg};

endmodule
`default_nettype wire

### verif/tb_set_assoc_cache_dram_timing.sv
// Self-checking testbench for the set-associative cache lookup with DRAM open-row timing.
`default_nettype none
module tb_set_assoc_cache_dram_timing;

    // Widths shared with the block
    localparam int ADDR_W      = sacd_pkg::ADDR_W;
    localparam int BYTE_BITS   = sacd_pkg::BYTE_BITS;
    localparam int COST_W      = sacd_pkg::COST_W;
    localparam int TOTAL_W     = sacd_pkg::TOTAL_W;
    localparam int CFG_IDX_W   = sacd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = sacd_pkg::CFG_DATA_W;

    // Geometry matches the block's defaults
    localparam int WAYS        = sacd_pkg::DEF_WAYS;
    localparam int INDEX_BITS  = sacd_pkg::DEF_INDEX_BITS;
    localparam int WORD_BITS   = sacd_pkg::DEF_WORD_BITS;
    localparam int ROW_SHIFT   = sacd_pkg::DEF_ROW_SHIFT;
    localparam int SETS        = 1 << INDEX_BITS;
    localparam int OFFSET_BITS = BYTE_BITS + WORD_BITS;
    localparam int TAG_W       = ADDR_W - OFFSET_BITS - INDEX_BITS;
    localparam int ROW_W       = ADDR_W - ROW_SHIFT;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // No register lives at this index; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic              is_write;
    } access_req_t;

    typedef struct packed {
        logic               hit;
        logic               dram_used;
        logic               row_was_open;
        logic [COST_W-1:0]  access_cycles;
        logic [TOTAL_W-1:0] total_cycles;
    } access_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata  = '0;  // address[31:0]
    logic                  s_tuser  = 1'b0; // mode[0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // hit[0], dram_used[1], row_was_open[2], access_cycles[12:3], total_cycles[60:13]
    logic [63:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    set_assoc_cache_dram_timing #(
        .WAYS       (WAYS),
        .INDEX_BITS (INDEX_BITS),
        .WORD_BITS  (WORD_BITS),
        .ROW_SHIFT  (ROW_SHIFT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Cache and DRAM shadow state
    logic               valid_store [WAYS][SETS];
    logic [TAG_W-1:0]   tag_store   [WAYS][SETS];
    int unsigned        fill_way     = 0;
    logic [ROW_W-1:0]   open_row     = '0;
    logic               row_live     = 1'b0;
    logic [TOTAL_W-1:0] running_total = '0;
    sacd_pkg::timing_cfg_t timing = '{lookup_time: sacd_pkg::LOOKUP_TIME_RST,
                                      cas_time: sacd_pkg::CAS_TIME_RST,
                                      ras_time: sacd_pkg::RAS_TIME_RST};

    access_req_t    pending_accesses [$];
    access_result_t expected_results [$];
    int             items_queued   = 0;
    int             items_accepted = 0;
    int             error_count    = 0;
    int             quiet_cycles   = 0;
    logic           access_taken   = 1'b0;
    logic           cfg_taken      = 1'b0;
    logic           idle_enable    = 1'b1;
    int             send_gap       = 0;
    int             recv_stall     = 0;

    // Stimulus shaping: a few tags and sets that keep colliding
    logic [TAG_W-1:0]      tag_pool [8];
    logic [INDEX_BITS-1:0] hot_sets [4];
    logic [ADDR_W-1:0]     last_addr = '0;

    // Lookup, fill, row timing and cost of one access; updates the shadow state
    function automatic access_result_t predict_access(logic [ADDR_W-1:0] addr,
                                                       logic is_write);
        logic [TAG_W-1:0]      tag;
        logic [INDEX_BITS-1:0] set_idx;
        logic [ROW_W-1:0]      row;
        logic                  hit;
        logic                  row_open;
        int unsigned           cost;
        access_result_t        res;
        tag      = addr[ADDR_W-1 -: TAG_W];
        set_idx  = addr[OFFSET_BITS +: INDEX_BITS];
        row      = addr[ADDR_W-1:ROW_SHIFT];
        hit      = 1'b0;
        row_open = 1'b0;
        cost     = 0;
        for (int w = 0; w < WAYS; w++) begin
            if (valid_store[w][set_idx] && tag_store[w][set_idx] == tag) hit = 1'b1;
        end
        // Reads that hit stay off DRAM; everything else checks the open row
        if (!(hit && !is_write)) begin
            row_open = row_live && row == open_row;
            if (!row_open) open_row = row;
            row_live = 1'b1;
        end
        if (hit && !is_write) begin
            cost = 32'(timing.lookup_time);
        end else if (hit) begin
            cost = 32'(timing.lookup_time) + 32'd2 * 32'(timing.cas_time)
                 + (row_open ? 32'd0 : 32'(timing.ras_time));
        end else begin
            cost = 32'(sacd_pkg::DRAM_OVERHEAD)
                 + (is_write ? 32'd2 : 32'd1) * 32'(timing.cas_time)
                 + (row_open ? 32'd0 : 32'(timing.ras_time));
            valid_store[fill_way][set_idx] = 1'b1;
            tag_store[fill_way][set_idx]   = tag;
            fill_way = (fill_way + 1 >= WAYS) ? 0 : fill_way + 1;
        end
        if (TOTAL_MAX - running_total < TOTAL_W'(cost)) running_total = TOTAL_MAX;
        else running_total = running_total + TOTAL_W'(cost);
        res.hit           = hit;
        res.dram_used     = !(hit && !is_write);
        res.row_was_open  = row_open;
        res.access_cycles = cost[COST_W-1:0];
        res.total_cycles  = running_total;
        return res;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Access driver: one transfer per item, random idle bursts between them
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || access_taken) begin
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_accesses.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                s_tvalid <= 1'b0;
                send_gap <= $urandom_range(0, 4);
            end else begin
                access_req_t req;
                req = pending_accesses.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= req.addr;
                s_tuser  <= req.is_write;
            end
        end
    end

    // Result back-pressure in bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_stall > 0) begin
            m_tready   <= 1'b0;
            recv_stall <= recv_stall - 1;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            recv_stall <= $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: config shadow, prediction on access, compare on result, watchdog
    always @(posedge aclk) begin
        access_taken <= aresetn && s_tvalid && s_tready;
        cfg_taken    <= aresetn && cfg_valid && cfg_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sacd_pkg::REG_LOOKUP_TIME: timing.lookup_time = cfg_data[3:0];
                    sacd_pkg::REG_CAS_TIME:    timing.cas_time    = cfg_data;
                    sacd_pkg::REG_RAS_TIME:    timing.ras_time    = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_access(s_tdata, s_tuser));
                items_accepted++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no access outstanding: %h", m_tdata);
                    error_count++;
                end else begin
                    access_result_t want;
                    want = expected_results.pop_front();
                    check_field("hit", want.hit, m_tdata[0]);
                    check_field("dram_used", want.dram_used, m_tdata[1]);
                    check_field("row_was_open", want.row_was_open, m_tdata[2]);
                    check_field("access_cycles", want.access_cycles, m_tdata[12:3]);
                    check_field("total_cycles", want.total_cycles, m_tdata[60:13]);
                end
            end
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic queue_access(logic [ADDR_W-1:0] addr, logic is_write);
        access_req_t req;
        req.addr     = addr;
        req.is_write = is_write;
        pending_accesses.push_back(req);
        items_queued++;
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(logic [3:0] hit_t, logic [7:0] cas_t, logic [7:0] ras_t);
        // upper nibble of the lookup time write is junk that must be masked
        write_register(sacd_pkg::REG_LOOKUP_TIME, {4'($urandom_range(0, 15)), hit_t});
        write_register(sacd_pkg::REG_CAS_TIME, cas_t);
        write_register(sacd_pkg::REG_RAS_TIME, ras_t);
    endtask

    // Holds the sender until every access has its result, then lets the pipe settle
    task automatic wait_for_drain();
        do @(negedge aclk);
        while (items_accepted != items_queued || expected_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [ADDR_W-1:0] next_address();
        logic [ADDR_W-1:0] a;
        int                pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            a = $urandom();
        else if (pick < 5)
            a = {last_addr[ADDR_W-1:ROW_SHIFT], ROW_SHIFT'($urandom_range(0, 63))};
        else
            a = {tag_pool[$urandom_range(0, 7)], hot_sets[$urandom_range(0, 3)],
                 OFFSET_BITS'($urandom_range(0, 7))};
        last_addr = a;
        return a;
    endfunction

    task automatic run_random(int count);
        repeat (count) queue_access(next_address(), 1'($urandom_range(0, 1)));
        wait_for_drain();
    endtask

    initial begin
        for (int w = 0; w < WAYS; w++) begin
            for (int s = 0; s < SETS; s++) begin
                valid_store[w][s] = 1'b0;
                tag_store[w][s]   = '0;
            end
        end
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < 8; i++) tag_pool[i] = TAG_W'($urandom());
        hot_sets[0] = '0;
        hot_sets[1] = '1;
        for (int i = 2; i < 4; i++) hot_sets[i] = INDEX_BITS'($urandom());

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: cold miss, hits, write hit on open row, address extremes, eviction
        queue_access(32'h0000_0000, 1'b0);
        queue_access(32'h0000_0004, 1'b0);
        queue_access(32'h0000_0000, 1'b1);
        queue_access(32'h0000_0800, 1'b1);
        queue_access(32'h0000_0800, 1'b0);
        queue_access(32'hFFFF_FFFF, 1'b0);
        queue_access(32'hFFFF_FFFF, 1'b1);
        queue_access(32'hFFFF_FFC0, 1'b0);
        for (int t = 2; t < 8; t++) queue_access({21'(t), 8'h10, 3'd0}, t[0]);
        queue_access({21'd2, 8'h10, 3'd0}, 1'b0);
        queue_access({21'd7, 8'h10, 3'd5}, 1'b0);
        queue_access(32'h5555_5555, 1'b1);
        queue_access(32'hAAAA_AAAA, 1'b0);
        queue_access(32'hAAAA_AAAA, 1'b1);
        wait_for_drain();

        // Largest costs, plus a write to the unused index that must change nothing
        set_timing(4'd15, 8'd255, 8'd255);
        write_register(REG_UNUSED, 8'hA5);
        queue_access(32'h1234_5678, 1'b1);
        queue_access(32'h1234_5678, 1'b1);
        queue_access(32'h8765_4321, 1'b1);
        run_random(300);

        // Smallest costs
        set_timing(4'd1, 8'd0, 8'd0);
        run_random(300);

        repeat (2) begin
            set_timing(4'($urandom_range(1, 15)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
            run_random(400);
        end

        // Full-rate tail with no idling on either side
        set_timing(4'($urandom_range(1, 15)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        idle_enable = 1'b0;
        run_random(600);

        repeat (10) @(negedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
design/sacd_pkg.sv
design/sacd_ram.sv
design/sacd_cost.sv
design/set_assoc_cache_dram_timing.sv
verif/tb_set_assoc_cache_dram_timing.sv
